### hw/rtl/srmq_pkg.sv
// Package for the sparse-table range-minimum block: sizes, codes, types and
// the leading-one search. No dependencies; every other file but srmq_ram uses it.
`timescale 1ns / 1ps
`default_nettype none

package srmq_pkg;

  localparam int MAX_LEN       = 1024;
  localparam int IDX_BITS      = 10;
  localparam int CNT_BITS      = 11;
  localparam int WIDE_BITS     = 12;
  localparam int LEVELS        = 11;
  localparam int LVL_BITS      = 4;
  localparam int VALUE_BITS    = 16;
  localparam int TBL_DEPTH     = LEVELS * MAX_LEN;
  localparam int TBL_ADDR_BITS = LVL_BITS + IDX_BITS;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;
  typedef logic [WIDE_BITS-1:0]     wide_t;
  typedef logic [LVL_BITS-1:0]      lvl_t;
  typedef logic [VALUE_BITS-1:0]    val_t;
  typedef logic [TBL_ADDR_BITS-1:0] tbl_addr_t;

  // Operands of the shared compare unit and its answer.
  typedef struct packed {
    idx_t a;
    idx_t b;
    val_t va;
    val_t vb;
  } pick_in_t;

  typedef struct packed {
    idx_t pos;
    val_t value;
  } pick_out_t;

  // Position of the highest set bit, capped at the top table level.
  function automatic lvl_t leading_one(input cnt_t x);
    lvl_t k;
    k = '0;
    for (int n = 0; n < CNT_BITS; n++) begin
      if (x[n]) begin
        k = LVL_BITS'(n);
      end
    end
    if (k > LVL_BITS'(LEVELS - 1)) begin
      k = LVL_BITS'(LEVELS - 1);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/srmq_in_if.sv
// Input channel of the range-minimum block: valid/ready and one item.
// Depends on srmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srmq_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  srmq_pkg::val_t    depth_value;
  logic              last_value;
  srmq_pkg::idx_t    left_index;
  srmq_pkg::idx_t    right_index;

  modport source(output valid, op, depth_value, last_value, left_index, right_index,
                 input ready);
  modport sink(input valid, op, depth_value, last_value, left_index, right_index,
               output ready);
endinterface

`default_nettype wire

### hw/rtl/srmq_out_if.sv
// Result channel of the range-minimum block: valid/ready and one result.
// Depends on srmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srmq_out_if;
  logic              valid;
  logic              ready;
  srmq_pkg::idx_t    min_position;
  srmq_pkg::val_t    min_value;
  logic              range_error;

  modport source(output valid, min_position, min_value, range_error, input ready);
  modport sink(input valid, min_position, min_value, range_error, output ready);
endinterface

`default_nettype wire

### hw/rtl/srmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/srmq_pick.sv
// Shared compare unit: picks the smaller of two stored values, the second
// operand winning a tie. Depends on srmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srmq_pick (
  input  wire srmq_pkg::pick_in_t operands,
  output srmq_pkg::pick_out_t     answer
);

  always_comb begin
    if (operands.va < operands.vb) begin
      answer.pos   = operands.a;
      answer.value = operands.va;
    end else begin
      answer.pos   = operands.b;
      answer.value = operands.vb;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/srmq_ctrl.sv
// Sequencer of the range-minimum block: the table build and queries run
// through the same four-step read/compare walk. Depends on srmq_pkg,
// srmq_in_if and srmq_out_if.
`timescale 1ns / 1ps
`default_nettype none

module srmq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  srmq_in_if.sink                     items,
  srmq_out_if.source                  results,
  output srmq_pkg::pick_in_t          pick_req,
  input  wire srmq_pkg::pick_out_t    pick_ans,
  output logic                        val_we,
  output srmq_pkg::idx_t              val_waddr,
  output srmq_pkg::val_t              val_wdata,
  output srmq_pkg::idx_t              val_raddr,
  input  wire srmq_pkg::val_t         val_rdata,
  output logic                        tbl_we,
  output srmq_pkg::tbl_addr_t         tbl_waddr,
  output srmq_pkg::idx_t              tbl_wdata,
  output srmq_pkg::tbl_addr_t         tbl_raddr,
  input  wire srmq_pkg::idx_t         tbl_rdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LVL  = 3'd1;
  localparam logic [2:0] ST_RA   = 3'd2;
  localparam logic [2:0] ST_RB   = 3'd3;
  localparam logic [2:0] ST_VA   = 3'd4;
  localparam logic [2:0] ST_VB   = 3'd5;

  logic [2:0]          state;
  logic                is_query;
  logic                table_ready;
  srmq_pkg::cnt_t      loaded_count;
  srmq_pkg::lvl_t      lvl;
  srmq_pkg::idx_t      idx_a;
  srmq_pkg::idx_t      idx_b;
  srmq_pkg::idx_t      pos_a;
  srmq_pkg::idx_t      pos_b;
  srmq_pkg::val_t      val_a;
  logic                out_valid;
  srmq_pkg::idx_t      out_position;
  srmq_pkg::val_t      out_value;
  logic                out_error;

  logic                slot_free;
  logic                take;
  logic                out_load;
  srmq_pkg::lvl_t      rd_lvl;
  srmq_pkg::idx_t      second_idx;
  srmq_pkg::wide_t     span;
  logic                store_full;
  srmq_pkg::idx_t      q_lo;
  srmq_pkg::idx_t      q_hi;
  srmq_pkg::cnt_t      q_len;
  srmq_pkg::lvl_t      q_lvl;
  srmq_pkg::cnt_t      q_rb;
  logic                q_bad;

  assign slot_free   = !out_valid || results.ready;
  assign items.ready = (state == ST_IDLE) && slot_free;
  assign take        = items.valid && items.ready;

  // A result beat is loaded by a rejected query or at the end of a query walk.
  assign out_load = ((state == ST_IDLE) && take && (items.op == srmq_pkg::OP_QUERY) && q_bad)
                  || ((state == ST_VB) && is_query && slot_free);

  assign results.valid        = out_valid;
  assign results.min_position = out_position;
  assign results.min_value    = out_value;
  assign results.range_error  = out_error;

  // The build reads the level below the one it writes; a query reads its own.
  assign rd_lvl     = is_query ? lvl : lvl - srmq_pkg::LVL_BITS'(1);
  assign second_idx = is_query ? idx_b
                               : idx_a + (srmq_pkg::IDX_BITS'(1) << rd_lvl);
  assign span       = srmq_pkg::WIDE_BITS'(1) << lvl;
  assign store_full = loaded_count >= srmq_pkg::CNT_BITS'(srmq_pkg::MAX_LEN);

  // Query setup: order the ends, then cover the range with two blocks.
  always_comb begin
    if (items.left_index > items.right_index) begin
      q_lo = items.right_index;
      q_hi = items.left_index;
    end else begin
      q_lo = items.left_index;
      q_hi = items.right_index;
    end
    q_len = srmq_pkg::CNT_BITS'(q_hi) - srmq_pkg::CNT_BITS'(q_lo)
          + srmq_pkg::CNT_BITS'(1);
    q_lvl = srmq_pkg::leading_one(q_len);
    q_rb  = srmq_pkg::CNT_BITS'(q_hi) + srmq_pkg::CNT_BITS'(1)
          - (srmq_pkg::CNT_BITS'(1) << q_lvl);
    q_bad = !table_ready || (srmq_pkg::CNT_BITS'(q_hi) >= loaded_count);
  end

  assign pick_req.a  = pos_a;
  assign pick_req.b  = pos_b;
  assign pick_req.va = val_a;
  assign pick_req.vb = val_rdata;

  // Memory ports.
  always_comb begin
    val_we    = take && (items.op == srmq_pkg::OP_LOAD) && !store_full;
    val_waddr = loaded_count[srmq_pkg::IDX_BITS-1:0];
    val_wdata = items.depth_value;

    case (state)
      ST_RB, ST_VA: val_raddr = tbl_rdata;
      ST_VB:        val_raddr = pos_b;
      default:      val_raddr = pos_a;
    endcase

    // Level zero is the identity and is written as each value arrives.
    if (state == ST_VB) begin
      tbl_we    = !is_query;
      tbl_waddr = {lvl, idx_a};
      tbl_wdata = pick_ans.pos;
    end else begin
      tbl_we    = val_we;
      tbl_waddr = {srmq_pkg::LVL_BITS'(0), loaded_count[srmq_pkg::IDX_BITS-1:0]};
      tbl_wdata = loaded_count[srmq_pkg::IDX_BITS-1:0];
    end

    case (state)
      ST_RB:   tbl_raddr = {rd_lvl, second_idx};
      default: tbl_raddr = {rd_lvl, idx_a};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      is_query     <= 1'b0;
      table_ready  <= 1'b0;
      loaded_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (take) begin
            if (items.op == srmq_pkg::OP_LOAD) begin
              is_query    <= 1'b0;
              table_ready <= 1'b0;
              if (!store_full) begin
                loaded_count <= loaded_count + srmq_pkg::CNT_BITS'(1);
              end
              if (items.last_value) begin
                lvl   <= srmq_pkg::LVL_BITS'(1);
                idx_a <= '0;
                state <= ST_LVL;
              end
            end else if (q_bad) begin
              out_position <= '0;
              out_value    <= '0;
              out_error    <= 1'b1;
            end else begin
              is_query <= 1'b1;
              lvl      <= q_lvl;
              idx_a    <= q_lo;
              idx_b    <= q_rb[srmq_pkg::IDX_BITS-1:0];
              state    <= ST_RA;
            end
          end
        end

        ST_LVL: begin
          if ((lvl <= srmq_pkg::LVL_BITS'(srmq_pkg::LEVELS - 1)) &&
              (span <= srmq_pkg::WIDE_BITS'(loaded_count))) begin
            state <= ST_RA;
          end else begin
            table_ready <= 1'b1;
            state       <= ST_IDLE;
          end
        end

        ST_RA: begin
          state <= ST_RB;
        end

        ST_RB: begin
          pos_a <= tbl_rdata;
          state <= ST_VA;
        end

        ST_VA: begin
          pos_b <= tbl_rdata;
          val_a <= val_rdata;
          state <= ST_VB;
        end

        ST_VB: begin
          if (is_query) begin
            if (slot_free) begin
              out_position <= pick_ans.pos;
              out_value    <= pick_ans.value;
              out_error    <= 1'b0;
              state        <= ST_IDLE;
            end
          end else if (srmq_pkg::WIDE_BITS'(idx_a) + srmq_pkg::WIDE_BITS'(1) + span
                       <= srmq_pkg::WIDE_BITS'(loaded_count)) begin
            idx_a <= idx_a + srmq_pkg::IDX_BITS'(1);
            state <= ST_RA;
          end else begin
            lvl   <= lvl + srmq_pkg::LVL_BITS'(1);
            idx_a <= '0;
            state <= ST_LVL;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sparse_table_range_minimum.sv
// Range-minimum engine over a sparse table of block minima.
//
// Channels: "items" carries loads (op 0: one depth value appended at the
// next position) and queries (op 1: two positions, in either order);
// "results" returns one beat per query with the position and value of the
// range minimum, or range_error set when no table is built or the range
// reaches past the loaded length. Loads return nothing.
// Flow: a load without the last mark is stored and leaves the sequencer
// idle. A load marked last then builds the table: each table entry runs
// the four-step walk (two reads of the table RAM, two of the value RAM,
// one compare), with a level check before each level and a last check
// that marks the table built. A query orders its ends and finds the level
// as it is taken, then runs the same four-step walk through the single
// read ports of the two RAMs. An out-of-range query is answered from idle
// with an error beat. The items channel is ready only while the sequencer is idle.
// Reset (synchronous, active high) empties the store and marks the table
// as not built; no memory clearing is needed. A stalled result waits in
// the output register; the next item is taken once that beat can leave.
// Depends on srmq_pkg, srmq_in_if, srmq_out_if, srmq_ram, srmq_pick and
// srmq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_range_minimum (
  input  wire logic   clk,
  input  wire logic   rst,
  srmq_in_if.sink     items,
  srmq_out_if.source  results
);

  srmq_pkg::pick_in_t  pick_req;
  srmq_pkg::pick_out_t pick_ans;

  logic                val_we;
  srmq_pkg::idx_t      val_waddr;
  srmq_pkg::val_t      val_wdata;
  srmq_pkg::idx_t      val_raddr;
  srmq_pkg::val_t      val_rdata;
  logic                tbl_we;
  srmq_pkg::tbl_addr_t tbl_waddr;
  srmq_pkg::idx_t      tbl_wdata;
  srmq_pkg::tbl_addr_t tbl_raddr;
  srmq_pkg::idx_t      tbl_rdata;

  srmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .pick_req  (pick_req),
    .pick_ans  (pick_ans),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .val_raddr (val_raddr),
    .val_rdata (val_rdata),
    .tbl_we    (tbl_we),
    .tbl_waddr (tbl_waddr),
    .tbl_wdata (tbl_wdata),
    .tbl_raddr (tbl_raddr),
    .tbl_rdata (tbl_rdata)
  );

  srmq_pick u_pick (
    .operands (pick_req),
    .answer   (pick_ans)
  );

  srmq_ram #(
    .WIDTH (srmq_pkg::VALUE_BITS),
    .DEPTH (srmq_pkg::MAX_LEN)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  srmq_ram #(
    .WIDTH (srmq_pkg::IDX_BITS),
    .DEPTH (srmq_pkg::TBL_DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

endmodule

`default_nettype wire
